[src/aus_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aus_pkg
// Shared types and constants of the Annex B access unit splitter.
// ----------------------------------------------------------------------------
package aus_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  localparam logic [15:0] MAX_RANGES_RESET = 16'hFFFF;

  localparam logic [4:0] NAL_TYPE_MASK  = 5'h1F;
  localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
  localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;
  localparam logic [7:0] START_CODE_ONE = 8'h01;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;
  localparam logic [1:0] ZERO_RUN_FULL  = 2'd2;
  localparam int unsigned START_CODE_LEN = 3;

  // One result item of the output stream.
  typedef struct packed {
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic        has_range;
    logic        stream_done;
  } aus_result_t;

  // Everything one input byte causes: one result, or two when a picture
  // header on the final byte closes a unit just before end of stream.
  typedef struct packed {
    aus_result_t first;
    aus_result_t second;
    logic        has_second;
  } aus_event_t;

endpackage

[src/aus_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aus_front
// Byte classifier: start code search, NAL header decode, unit tracking.
// ----------------------------------------------------------------------------
module aus_front
  import aus_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        end_of_stream_i,
  input  logic [15:0] max_ranges_i,
  output logic        ev_valid_o,
  input  logic        ev_ready_i,
  output aus_event_t  ev_o
);

  localparam int unsigned PB = POSITION_BITS;

  logic [PB-1:0] pos_q, pos_d;
  logic [1:0]    zero_run_q, zero_run_d;
  logic          hdr_q, hdr_d;
  logic          started_q, started_d;
  logic [PB-1:0] ustart_q, ustart_d;
  logic          seen_q, seen_d;
  logic [15:0]   ranges_q, ranges_d;

  logic          accept;
  logic [4:0]    nal_type;
  logic          is_pic;
  logic [PB-1:0] sc_pos;
  logic          close_mid;
  logic [15:0]   ranges_mid;
  logic [PB-1:0] ustart_mid;
  logic          is_sc;
  logic          open_unit;
  logic          started_mid;
  logic [PB-1:0] ustart_fin;
  logic [PB-1:0] pos_next;
  logic          emit_last;
  aus_result_t   mid_res;
  aus_result_t   last_res;

  function automatic logic [31:0] to32(input logic [PB-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  always_comb begin
    accept      = in_valid_i && ev_ready_i;
    nal_type    = stream_byte_i[4:0] & NAL_TYPE_MASK;
    is_pic      = hdr_q && (nal_type == NAL_TYPE_SLICE || nal_type == NAL_TYPE_IDR);
    sc_pos      = pos_q - PB'(START_CODE_LEN);
    close_mid   = is_pic && seen_q && (ranges_q < max_ranges_i);
    ranges_mid  = ranges_q + 16'(close_mid);
    ustart_mid  = close_mid ? sc_pos : ustart_q;
    is_sc       = (stream_byte_i == START_CODE_ONE) && (zero_run_q == ZERO_RUN_FULL);
    open_unit   = is_sc && !started_q;
    started_mid = started_q || is_sc;
    ustart_fin  = open_unit ? (pos_q - PB'(START_CODE_LEN - 1)) : ustart_mid;
    pos_next    = pos_q + PB'(1);
    emit_last   = started_mid && (ranges_mid < max_ranges_i);

    mid_res.unit_offset = to32(ustart_q);
    mid_res.unit_length = to32(sc_pos - ustart_q);
    mid_res.has_range   = 1'b1;
    mid_res.stream_done = 1'b0;

    if (emit_last) begin
      last_res.unit_offset = to32(ustart_fin);
      last_res.unit_length = to32(pos_next - ustart_fin);
      last_res.has_range   = 1'b1;
    end else begin
      last_res.unit_offset = '0;
      last_res.unit_length = '0;
      last_res.has_range   = 1'b0;
    end
    last_res.stream_done = 1'b1;

    if (close_mid) begin
      ev_o.first      = mid_res;
      ev_o.second     = last_res;
      ev_o.has_second = end_of_stream_i;
    end else begin
      ev_o.first      = last_res;
      ev_o.second     = last_res;
      ev_o.has_second = 1'b0;
    end
    ev_valid_o = accept && (close_mid || end_of_stream_i);
    in_ready_o = ev_ready_i;

    pos_d      = pos_q;
    zero_run_d = zero_run_q;
    hdr_d      = hdr_q;
    started_d  = started_q;
    ustart_d   = ustart_q;
    seen_d     = seen_q;
    ranges_d   = ranges_q;
    if (accept) begin
      if (end_of_stream_i) begin
        pos_d      = '0;
        zero_run_d = '0;
        hdr_d      = 1'b0;
        started_d  = 1'b0;
        ustart_d   = '0;
        seen_d     = 1'b0;
        ranges_d   = '0;
      end else begin
        pos_d     = pos_next;
        hdr_d     = is_sc;
        started_d = started_mid;
        ustart_d  = ustart_fin;
        seen_d    = seen_q || is_pic;
        ranges_d  = ranges_mid;
        if (stream_byte_i == ZERO_BYTE) begin
          zero_run_d = (zero_run_q == ZERO_RUN_FULL) ? zero_run_q : zero_run_q + 2'd1;
        end else begin
          zero_run_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      zero_run_q <= '0;
      hdr_q      <= 1'b0;
      started_q  <= 1'b0;
      ustart_q   <= '0;
      seen_q     <= 1'b0;
      ranges_q   <= '0;
    end else begin
      pos_q      <= pos_d;
      zero_run_q <= zero_run_d;
      hdr_q      <= hdr_d;
      started_q  <= started_d;
      ustart_q   <= ustart_d;
      seen_q     <= seen_d;
      ranges_q   <= ranges_d;
    end
  end

  // A two-result event is always a mid-stream range followed by the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o && ev_o.has_second |->
      !ev_o.first.stream_done && ev_o.second.stream_done)
    else $error("aus_front: malformed two-result event");

  // Header flag only follows a start code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q |-> started_q && zero_run_q == '0)
    else $error("aus_front: header expected outside a unit");

endmodule

[src/aus_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aus_queue
// Short event FIFO between the classifier and the output stage.
// ----------------------------------------------------------------------------
module aus_queue
  import aus_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  aus_event_t push_ev_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output aus_event_t pop_ev_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  aus_event_t    mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    push_ready_o = (count_q != CW'(DEPTH));
    pop_valid_o  = (count_q != '0);
    pop_ev_o     = mem_q[rd_ptr_q];
    do_push      = push_valid_i && push_ready_o;
    do_pop       = pop_valid_o && pop_ready_i;
    wr_ptr_d     = do_push ? wrap_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d     = do_pop ? wrap_inc(rd_ptr_q) : rd_ptr_q;
    count_d      = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_ev_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("aus_queue: fill count overflow");

endmodule

[src/aus_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aus_back
// Output stage: unpacks events into result transactions, one per cycle while the output is taken.
// ----------------------------------------------------------------------------
module aus_back
  import aus_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  aus_event_t  pop_ev_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output aus_result_t out_res_o
);

  logic        out_vld_q, out_vld_d;
  aus_result_t out_q, out_d;
  logic        pend_q, pend_d;
  aus_result_t pend_res_q, pend_res_d;
  logic        load;

  always_comb begin
    load        = !out_vld_q || out_ready_i;
    pop_ready_o = load && !pend_q;
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    if (load) begin
      if (pend_q) begin
        // hold the second result of a pair until the first is taken
        out_d     = pend_res_q;
        out_vld_d = 1'b1;
        pend_d    = 1'b0;
      end else if (pop_valid_i) begin
        out_d      = pop_ev_i.first;
        out_vld_d  = 1'b1;
        pend_d     = pop_ev_i.has_second;
        pend_res_d = pop_ev_i.second;
      end else begin
        out_vld_d = 1'b0;
      end
    end
    out_valid_o = out_vld_q;
    out_res_o   = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    pend_res_q <= pend_res_d;
  end

  // A pending second result exists only behind a shown first one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_vld_q && !out_q.stream_done)
    else $error("aus_back: orphaned second result");

  // An empty terminator carries no range and closes the stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.has_range |->
      out_q.unit_offset == '0 && out_q.unit_length == '0 && out_q.stream_done)
    else $error("aus_back: malformed terminator");

endmodule

[src/annexb_access_unit_splitter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter_core
// Splits an H.264 Annex B byte stream into access unit byte ranges.
// ----------------------------------------------------------------------------
// The core takes one stream byte per clock on the slave stream (tlast on the
// final byte of a stream) and reports each access unit as an offset/length
// pair on the master stream. A unit starts at its first 00 00 01 start code;
// it closes when a slice or IDR header arrives while the unit already holds
// one, and at end of stream. Bytes ahead of the first start code are dropped;
// a stream without a start code, or whose last range is over the limit in
// max_ranges, ends in a terminator with tuser low. tlast marks the last result
// of each stream. Input bytes pass through the classifier with no stall of
// their own: tready drops only while the result queue is full, which happens
// when the downstream side holds off. Results leave at one per cycle from the
// output register while the downstream side accepts them; a byte that yields
// two results (a unit closed by a header on the final byte) sends them as two
// transactions, absorbed by the queue. Write max_ranges only between streams.
// Streams must stay shorter than 2^POSITION_BITS bytes.
// ----------------------------------------------------------------------------
module annexb_access_unit_splitter_core
  import aus_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_ranges
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tlast,   // end_of_stream
  // unit ranges out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] unit_offset, [63:32] unit_length
  output logic        m_axis_tuser,   // has_range
  output logic        m_axis_tlast    // stream_done
);

  logic [15:0] max_ranges_q;
  logic        ev_valid, ev_ready;
  aus_event_t  ev;
  logic        pop_valid, pop_ready;
  aus_event_t  pop_ev;
  aus_result_t res;

  // Take configuration writes at any time; software keeps them between streams.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ranges_q <= MAX_RANGES_RESET;
    end else if (cfg_valid_i) begin
      max_ranges_q <= cfg_data_i;
    end
  end

  // Classify each byte and track the open unit.
  aus_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .stream_byte_i  (s_axis_tdata),
    .end_of_stream_i(s_axis_tlast),
    .max_ranges_i   (max_ranges_q),
    .ev_valid_o     (ev_valid),
    .ev_ready_i     (ev_ready),
    .ev_o           (ev)
  );

  // Decouple classification from output backpressure.
  aus_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(ev_valid),
    .push_ready_o(ev_ready),
    .push_ev_i   (ev),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_ev_o    (pop_ev)
  );

  // Drain events one result transaction at a time.
  aus_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_ev_i   (pop_ev),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res)
  );

  assign m_axis_tdata = {res.unit_length, res.unit_offset};
  assign m_axis_tuser = res.has_range;
  assign m_axis_tlast = res.stream_done;

  // Every event from the classifier finds room in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid |-> ev_ready)
    else $error("core: result event dropped");

endmodule
